// File: rtl/core/pod_pkg.sv
// Shared operation and status codes and controller command type for the page directory.
`timescale 1ns / 1ps

package pod_pkg;

  localparam int MASK_W = 4;

  typedef enum logic [2:0] {
    OP_READ         = 3'd0,
    OP_WRITE        = 3'd1,
    OP_LEASE        = 3'd2,
    OP_PAGE_COMMIT  = 3'd3,
    OP_LEASE_COMMIT = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED       = 3'd0,
    ST_RETRY_OWNER   = 3'd1,
    ST_RETRY_BUSY    = 3'd2,
    ST_BAD_REQUEST   = 3'd3,
    ST_BAD_PAGE      = 3'd4,
    ST_COMMIT_OK     = 3'd5,
    ST_COMMIT_DENIED = 3'd6
  } status_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } pod_cmd_t;

endpackage

// File: rtl/core/pod_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/pod_ctrl.sv
// Handshake controller: sequences lookup and decision for one item at a time.
`timescale 1ns / 1ps

module pod_ctrl
  import pod_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pod_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  pod_cmd_t cmd;

  always_comb begin
    cmd.capture = (state_q == S_IDLE) && in_valid_i;
    cmd.execute = (state_q == S_LOOKUP) && (!out_valid_q || !out_stall_i);
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (cmd.capture) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (cmd.execute) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  a_exec_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.execute |=> out_valid_q)
    else $error("decision not presented");
  a_rise_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd.execute))
    else $error("result appeared without a decision");
  a_capture_then_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> (state_q == S_LOOKUP) && in_stall_o)
    else $error("item captured without lookup");

endmodule

// File: rtl/core/pod_datapath.sv
// Directory datapath: page table memory, lease token and decision logic.
`timescale 1ns / 1ps

module pod_datapath
  import pod_pkg::*;
#(
  parameter int NODE_COUNT = 4,
  parameter int PAGE_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pod_cmd_t          cmd_i,
  input  logic [2:0]        operation_i,
  input  logic [7:0]        page_index_i,
  input  logic [2:0]        requester_node_i,
  input  logic [2:0]        server_node_i,
  output logic [2:0]        status_o,
  output logic [2:0]        response_owner_o,
  output logic [MASK_W-1:0] invalidate_mask_o,
  output logic [MASK_W-1:0] prior_readers_o
);

  localparam int OW    = $clog2(NODE_COUNT);
  localparam int CW    = (OW > 3) ? OW : 3;
  localparam int AW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int SLOTS = 2 ** AW;
  localparam int EW    = OW + MASK_W + 1;

  logic [2:0]    op_q;
  logic [AW-1:0] addr_q;
  logic          in_range_q;
  logic [2:0]    req_q;
  logic [2:0]    srv_q;
  logic          valid_rd_q;
  logic [SLOTS-1:0] valid_q;
  logic [OW-1:0] tok_owner_q, tok_owner_d;
  logic          tok_busy_q, tok_busy_d;

  logic [2:0]        status_q;
  logic [2:0]        resp_owner_q;
  logic [MASK_W-1:0] inval_q;
  logic [MASK_W-1:0] readers_q;

  logic [OW-1:0] reset_owner [SLOTS];
  logic [AW-1:0] in_addr;
  logic          in_range;
  logic [EW-1:0] rdata;
  logic [OW-1:0] ram_owner, cur_owner;
  logic [MASK_W-1:0] ram_readers, cur_readers;
  logic          ram_busy, cur_busy;
  logic [MASK_W-1:0] req_bit;
  logic          bad_req;
  logic          owner_is_srv;
  logic          owner_is_req;
  logic          tok_is_srv;
  logic          tok_is_req;

  status_e           st_c;
  logic [2:0]        own_c;
  logic [MASK_W-1:0] inv_c;
  logic [MASK_W-1:0] rb_c;
  logic              we_c;
  logic [EW-1:0]     wdata_c;
  logic              ram_we;

  for (genvar p = 0; p < SLOTS; p++) begin : g_reset_owner
    assign reset_owner[p] = OW'(p % NODE_COUNT);
  end

  assign in_addr  = page_index_i[AW-1:0];
  assign in_range = (9'(page_index_i) < 9'(PAGE_COUNT));

  pod_ram #(
    .WIDTH(EW),
    .DEPTH(PAGE_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(wdata_c),
    .re_i   (cmd_i.capture && in_range),
    .raddr_i(in_addr),
    .rdata_o(rdata)
  );

  assign {ram_owner, ram_readers, ram_busy} = rdata;

  assign cur_owner   = valid_rd_q ? ram_owner : reset_owner[addr_q];
  assign cur_readers = valid_rd_q ? ram_readers : '0;
  assign cur_busy    = valid_rd_q && ram_busy;

  assign req_bit      = MASK_W'(8'd1 << req_q);
  assign bad_req      = (5'(req_q) >= 5'(NODE_COUNT)) || (req_q == srv_q);
  assign owner_is_srv = (CW'(cur_owner) == CW'(srv_q));
  assign owner_is_req = (CW'(cur_owner) == CW'(req_q));
  assign tok_is_srv   = (CW'(tok_owner_q) == CW'(srv_q));
  assign tok_is_req   = (CW'(tok_owner_q) == CW'(req_q));

  always_comb begin
    st_c        = ST_BAD_REQUEST;
    own_c       = '0;
    inv_c       = '0;
    rb_c        = '0;
    we_c        = 1'b0;
    wdata_c     = {cur_owner, cur_readers, cur_busy};
    tok_owner_d = tok_owner_q;
    tok_busy_d  = tok_busy_q;
    unique case (op_q) inside
      OP_LEASE_COMMIT: begin
        if (tok_is_req && tok_busy_q) begin
          st_c       = ST_COMMIT_OK;
          tok_busy_d = 1'b0;
        end else begin
          st_c = ST_COMMIT_DENIED;
        end
      end
      OP_PAGE_COMMIT: begin
        if (!in_range_q) begin
          st_c = ST_BAD_PAGE;
        end else begin
          rb_c = cur_readers;
          if (owner_is_req && cur_busy) begin
            st_c    = ST_COMMIT_OK;
            we_c    = 1'b1;
            wdata_c = {cur_owner, cur_readers, 1'b0};
          end else begin
            st_c = ST_COMMIT_DENIED;
          end
        end
      end
      OP_READ, OP_WRITE, OP_LEASE: begin
        if (bad_req) begin
          st_c = ST_BAD_REQUEST;
        end else if (op_q == OP_LEASE) begin
          if (!tok_is_srv) begin
            st_c  = ST_RETRY_OWNER;
            own_c = 3'(tok_owner_q);
          end else if (tok_busy_q) begin
            st_c  = ST_RETRY_BUSY;
            own_c = 3'(tok_owner_q);
          end else begin
            st_c        = ST_GRANTED;
            own_c       = srv_q;
            tok_owner_d = OW'(req_q);
            tok_busy_d  = 1'b1;
          end
        end else if (!in_range_q) begin
          st_c = ST_BAD_PAGE;
        end else begin
          rb_c = cur_readers;
          if (!owner_is_srv) begin
            st_c  = ST_RETRY_OWNER;
            own_c = 3'(cur_owner);
          end else if (cur_busy) begin
            st_c  = ST_RETRY_BUSY;
            own_c = 3'(cur_owner);
          end else begin
            st_c  = ST_GRANTED;
            own_c = srv_q;
            we_c  = 1'b1;
            if (op_q == OP_READ) begin
              wdata_c = {cur_owner, cur_readers | req_bit, 1'b0};
            end else begin
              inv_c   = cur_readers & ~req_bit;
              wdata_c = {OW'(req_q), {MASK_W{1'b0}}, 1'b1};
            end
          end
        end
      end
      default: st_c = ST_BAD_REQUEST;
    endcase
  end

  assign ram_we = cmd_i.execute && we_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      tok_owner_q <= '0;
      tok_busy_q  <= 1'b0;
    end else if (cmd_i.execute) begin
      tok_owner_q <= tok_owner_d;
      tok_busy_q  <= tok_busy_d;
      if (we_c) begin
        valid_q[addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= operation_i;
      addr_q     <= in_addr;
      in_range_q <= in_range;
      req_q      <= requester_node_i;
      srv_q      <= server_node_i;
      valid_rd_q <= valid_q[in_addr];
    end
    if (cmd_i.execute) begin
      status_q     <= st_c;
      resp_owner_q <= own_c;
      inval_q      <= inv_c;
      readers_q    <= rb_c;
    end
  end

  assign status_o          = status_q;
  assign response_owner_o  = resp_owner_q;
  assign invalidate_mask_o = inval_q;
  assign prior_readers_o   = readers_q;

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(addr_q)])
    else $error("written page not marked valid");
  a_lease_grant_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && (op_q == OP_LEASE) && (st_c == ST_GRANTED) |=> tok_busy_q)
    else $error("lease grant left token idle");
  a_lease_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute && (op_q == OP_LEASE_COMMIT) && (st_c == ST_COMMIT_OK)
    |=> !tok_busy_q)
    else $error("lease commit left token busy");

endmodule

// File: rtl/core/page_ownership_directory.sv
// Top level of the page ownership directory.
`timescale 1ns / 1ps
//
// Central coherence directory: per page an owner, a reader mask and a busy
// mark, plus one lease token. Requests enter on the in channel
// (operation, page_index, requester_node, server_node) and each gives one
// decision on the out channel (status, response_owner, invalidate_mask,
// prior_readers). Both channels use valid/stall; an item moves when valid
// is high and stall is low.
// A result is registered once its item has been looked up and the output
// register is free. A new item is taken only after the last one's decision,
// as the page table memory is read-modify-written (read at accept, write at
// the decision).
// Reset clears per-page valid bits and the token; a page never written reads
// as owner page mod node count with no readers and not busy. No clearing
// pass is needed, so items are taken right after reset.
// While the receiver stalls, the result is held; one more item is accepted
// and looked up, then waits until the output register frees.
//
module page_ownership_directory
  import pod_pkg::*;
#(
  parameter int NODE_COUNT = 4,
  parameter int PAGE_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        operation_i,
  input  logic [7:0]        page_index_i,
  input  logic [2:0]        requester_node_i,
  input  logic [2:0]        server_node_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [2:0]        response_owner_o,
  output logic [MASK_W-1:0] invalidate_mask_o,
  output logic [MASK_W-1:0] prior_readers_o
);

  pod_cmd_t cmd;

  pod_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  pod_datapath #(
    .NODE_COUNT(NODE_COUNT),
    .PAGE_COUNT(PAGE_COUNT)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .operation_i      (operation_i),
    .page_index_i     (page_index_i),
    .requester_node_i (requester_node_i),
    .server_node_i    (server_node_i),
    .status_o         (status_o),
    .response_owner_o (response_owner_o),
    .invalidate_mask_o(invalidate_mask_o),
    .prior_readers_o  (prior_readers_o)
  );

endmodule

// File: verif/page_ownership_directory_test.sv
// Self-checking testbench for the page ownership directory: queued stimulus, predictor, checker.
`timescale 1ns / 1ps

module page_ownership_directory_test;
  import pod_pkg::*;

  localparam int NODES          = 4;
  localparam int PAGES          = 16;
  localparam int RANDOM_ITEMS   = 450;
  localparam int PHASE_LEN      = 150;
  localparam int LOG_DEPTH      = 1024;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  page;
    logic [2:0]  req;
    logic [2:0]  srv;
    bit          aim;
    bit          hold;
    int unsigned phase;
  } dir_item_t;

  typedef struct packed {
    status_e             status;
    logic [2:0]          owner;
    logic [MASK_W-1:0]   inval;
    logic [MASK_W-1:0]   readers;
  } decision_t;

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall_o;
  logic [2:0]        operation = '0;
  logic [7:0]        page_index = '0;
  logic [2:0]        requester_node = '0;
  logic [2:0]        server_node = '0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  logic [2:0]        status_o;
  logic [2:0]        response_owner_o;
  logic [MASK_W-1:0] invalidate_mask_o;
  logic [MASK_W-1:0] prior_readers_o;

  logic [1:0]        owner_tbl  [PAGES];
  logic [MASK_W-1:0] reader_tbl [PAGES];
  logic [2:0]        busy_tbl   [PAGES];
  logic [1:0]        tok_owner;
  logic [2:0]        tok_busy;

  dir_item_t   pending[$];
  dir_item_t   cur;
  decision_t   decision_log [LOG_DEPTH];
  int unsigned issued = 0;
  int unsigned checked = 0;
  int unsigned total_items = 0;
  int unsigned mismatches = 0;
  int unsigned quiet = 0;
  int unsigned cur_phase = 0;
  int unsigned tx_idle_pct [3] = '{25, 66, 0};
  int unsigned rx_stall_pct [3] = '{66, 25, 0};

  page_ownership_directory #(
    .NODE_COUNT(NODES),
    .PAGE_COUNT(PAGES)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation),
    .page_index_i     (page_index),
    .requester_node_i (requester_node),
    .server_node_i    (server_node),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .status_o         (status_o),
    .response_owner_o (response_owner_o),
    .invalidate_mask_o(invalidate_mask_o),
    .prior_readers_o  (prior_readers_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic reset_directory();
    for (int p = 0; p < PAGES; p++) begin
      owner_tbl[p]  = 2'(p % NODES);
      reader_tbl[p] = '0;
      busy_tbl[p]   = '0;
    end
    tok_owner = '0;
    tok_busy  = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("decision %0d: %s", checked, msg);
    mismatches++;
  endtask

  task automatic queue_item(input logic [2:0] op, input logic [7:0] page, input logic [2:0] req,
                            input logic [2:0] srv, input bit aim, input bit hold,
                            input int unsigned phase);
    dir_item_t it;
    it = '{op: op, page: page, req: req, srv: srv, aim: aim, hold: hold, phase: phase};
    pending.push_back(it);
    total_items++;
  endtask

  // Steer requests at the current owner and commits at the current holder.
  function automatic dir_item_t aim_item(input dir_item_t it);
    dir_item_t a;
    int        pg;
    a  = it;
    pg = it.page;
    if (it.aim) begin
      case (it.op)
        OP_READ, OP_WRITE: begin
          if (pg < PAGES) begin
            a.srv = 3'(owner_tbl[pg]);
            a.req = 3'((int'(a.srv) + $urandom_range(1, NODES - 1)) % NODES);
          end
        end
        OP_LEASE: begin
          a.srv = 3'(tok_owner);
          a.req = 3'((int'(a.srv) + $urandom_range(1, NODES - 1)) % NODES);
        end
        OP_PAGE_COMMIT: begin
          if (pg < PAGES) begin
            a.req = (busy_tbl[pg] != 0) ? busy_tbl[pg] - 3'd1 : 3'(owner_tbl[pg]);
          end
        end
        OP_LEASE_COMMIT: begin
          a.req = (tok_busy != 0) ? tok_busy - 3'd1 : 3'(tok_owner);
        end
        default: ;
      endcase
    end
    return a;
  endfunction

  function automatic decision_t predict_decision(input dir_item_t it);
    decision_t         d;
    logic [MASK_W-1:0] rd;
    int                pg;
    d  = '{status: ST_BAD_REQUEST, owner: '0, inval: '0, readers: '0};
    pg = it.page;
    case (it.op)
      OP_LEASE_COMMIT: begin
        if (3'(tok_owner) == it.req && 4'(tok_busy) == 4'(it.req) + 4'd1) begin
          tok_busy = '0;
          d.status = ST_COMMIT_OK;
        end else begin
          d.status = ST_COMMIT_DENIED;
        end
      end
      OP_PAGE_COMMIT: begin
        if (pg >= PAGES) begin
          d.status = ST_BAD_PAGE;
        end else begin
          d.readers = reader_tbl[pg];
          if (3'(owner_tbl[pg]) == it.req && 4'(busy_tbl[pg]) == 4'(it.req) + 4'd1) begin
            busy_tbl[pg] = '0;
            d.status = ST_COMMIT_OK;
          end else begin
            d.status = ST_COMMIT_DENIED;
          end
        end
      end
      OP_READ, OP_WRITE, OP_LEASE: begin
        if (it.req >= NODES || it.req == it.srv) begin
          d.status = ST_BAD_REQUEST;
        end else if (it.op == OP_LEASE) begin
          if (3'(tok_owner) != it.srv) begin
            d.status = ST_RETRY_OWNER;
            d.owner  = 3'(tok_owner);
          end else if (tok_busy != 0) begin
            d.status = ST_RETRY_BUSY;
            d.owner  = 3'(tok_owner);
          end else begin
            tok_owner = it.req[1:0];
            tok_busy  = it.req + 3'd1;
            d.status  = ST_GRANTED;
            d.owner   = it.srv;
          end
        end else if (pg >= PAGES) begin
          d.status = ST_BAD_PAGE;
        end else begin
          rd        = reader_tbl[pg];
          d.readers = rd;
          if (3'(owner_tbl[pg]) != it.srv) begin
            d.status = ST_RETRY_OWNER;
            d.owner  = 3'(owner_tbl[pg]);
          end else if (busy_tbl[pg] != 0) begin
            d.status = ST_RETRY_BUSY;
            d.owner  = 3'(owner_tbl[pg]);
          end else if (it.op == OP_READ) begin
            reader_tbl[pg] = rd | (4'd1 << it.req);
            d.status = ST_GRANTED;
            d.owner  = it.srv;
          end else begin
            d.inval        = rd & ~(4'd1 << it.req);
            owner_tbl[pg]  = it.req[1:0];
            reader_tbl[pg] = '0;
            busy_tbl[pg]   = it.req + 3'd1;
            d.status = ST_GRANTED;
            d.owner  = it.srv;
          end
        end
      end
      default: d.status = ST_BAD_REQUEST;
    endcase
    return d;
  endfunction

  always @(posedge clk_i) begin
    int unsigned done_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      done_now = issued;
      if (in_valid && !in_stall_o) begin
        decision_log[issued] = predict_decision(cur);
        done_now = issued + 1;
        issued <= done_now;
      end
      if (!in_valid || !in_stall_o) begin
        if (pending.size() != 0 && !(pending[0].hold && checked != done_now) &&
            $urandom_range(99) >= tx_idle_pct[pending[0].phase]) begin
          cur = aim_item(pending.pop_front());
          in_valid       <= 1'b1;
          operation      <= cur.op;
          page_index     <= cur.page;
          requester_node <= cur.req;
          server_node    <= cur.srv;
          cur_phase      <= cur.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    decision_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (checked >= issued) begin
        report_mismatch("result with no pending decision");
      end else begin
        want = decision_log[checked];
        if (status_o != want.status)
          report_mismatch($sformatf("status got %0d want %0d", status_o, want.status));
        if (response_owner_o != want.owner)
          report_mismatch($sformatf("owner got %0d want %0d", response_owner_o, want.owner));
        if (invalidate_mask_o != want.inval)
          report_mismatch($sformatf("invalidate got %b want %b", invalidate_mask_o, want.inval));
        if (prior_readers_o != want.readers)
          report_mismatch($sformatf("readers got %b want %b", prior_readers_o, want.readers));
        checked <= checked + 1;
      end
    end
    out_stall <= rst_n ? ($urandom_range(99) < rx_stall_pct[cur_phase]) : 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("** page_ownership_directory: FAILED **");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned phase;
    logic [2:0]  op;
    logic [7:0]  page;
    bit          hold;

    reset_directory();

    queue_item(OP_READ, 8'd0, 3'd1, 3'd0, 0, 0, 0);
    queue_item(OP_READ, 8'd0, 3'd2, 3'd0, 0, 0, 0);
    queue_item(OP_READ, 8'd0, 3'd0, 3'd0, 0, 0, 0);
    queue_item(OP_READ, 8'd0, 3'd4, 3'd0, 0, 0, 0);
    queue_item(OP_WRITE, 8'd0, 3'd1, 3'd0, 0, 0, 0);
    queue_item(OP_READ, 8'd0, 3'd2, 3'd0, 0, 0, 0);
    queue_item(OP_READ, 8'd0, 3'd2, 3'd1, 0, 0, 0);
    queue_item(OP_PAGE_COMMIT, 8'd0, 3'd2, 3'd5, 0, 0, 0);
    queue_item(OP_PAGE_COMMIT, 8'd0, 3'd1, 3'd7, 0, 0, 0);
    queue_item(OP_READ, 8'd0, 3'd3, 3'd7, 0, 0, 0);
    queue_item(OP_READ, 8'd16, 3'd1, 3'd0, 0, 0, 0);
    queue_item(OP_WRITE, 8'd255, 3'd1, 3'd2, 0, 0, 0);
    queue_item(OP_PAGE_COMMIT, 8'd255, 3'd1, 3'd0, 0, 0, 0);
    queue_item(OP_PAGE_COMMIT, 8'd15, 3'd7, 3'd3, 0, 0, 0);
    queue_item(OP_LEASE, 8'd200, 3'd1, 3'd0, 0, 0, 0);
    queue_item(OP_LEASE, 8'd3, 3'd2, 3'd1, 0, 0, 0);
    queue_item(OP_LEASE, 8'd3, 3'd2, 3'd0, 0, 0, 0);
    queue_item(OP_LEASE_COMMIT, 8'd77, 3'd7, 3'd1, 0, 0, 0);
    queue_item(OP_LEASE_COMMIT, 8'd255, 3'd1, 3'd6, 0, 0, 0);
    queue_item(3'd5, 8'd1, 3'd1, 3'd0, 0, 0, 0);
    queue_item(3'd6, 8'd128, 3'd2, 3'd3, 0, 0, 0);
    queue_item(3'd7, 8'd255, 3'd7, 3'd7, 0, 0, 0);
    queue_item(OP_READ, 8'd15, 3'd0, 3'd3, 0, 0, 0);
    queue_item(OP_WRITE, 8'd15, 3'd2, 3'd3, 0, 0, 0);
    queue_item(OP_PAGE_COMMIT, 8'd15, 3'd2, 3'd0, 0, 0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = n / PHASE_LEN;
      hold  = (n == PHASE_LEN / 2) || (n % PHASE_LEN == 0);
      if ($urandom_range(99) < 80) begin
        roll = $urandom_range(99);
        if (roll < 30)      op = OP_READ;
        else if (roll < 55) op = OP_WRITE;
        else if (roll < 65) op = OP_LEASE;
        else if (roll < 85) op = OP_PAGE_COMMIT;
        else if (roll < 95) op = OP_LEASE_COMMIT;
        else                op = 3'($urandom_range(5, 7));
        page = ($urandom_range(19) == 0) ? 8'($urandom_range(PAGES, 255))
                                         : 8'($urandom_range(0, PAGES - 1));
        queue_item(op, page, 3'($urandom_range(NODES - 1)), 3'($urandom_range(NODES - 1)),
                   1, hold, phase);
      end else begin
        queue_item(3'($urandom_range(7)), 8'($urandom_range(255)), 3'($urandom_range(7)),
                   3'($urandom_range(7)), 0, hold, phase);
      end
    end

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    while (issued != total_items || checked != issued) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (checked != issued) report_mismatch("decisions left unchecked");
    if (mismatches == 0) begin
      $display("** page_ownership_directory: PASSED **");
    end else begin
      $display("** page_ownership_directory: FAILED **");
    end
    $finish;
  end

endmodule
